### sv/letter_run_length_encoder_assert.svh
// Assertion macros for the letter run-length encoder.
`ifndef LETTER_RUN_LENGTH_ENCODER_ASSERT_SVH
`define LETTER_RUN_LENGTH_ENCODER_ASSERT_SVH

// Implication checked on every edge outside reset.
`define LRLE_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Condition that must never hold outside reset.
`define LRLE_ASSERT_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error(msg);

`endif

### sv/lrle_pkg.sv
package lrle_pkg;

   localparam int COUNT_BITS_DEFAULT  = 16;
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   localparam int LEN_MAX_BITS   = 16;
   localparam int DIGITS         = 5;
   localparam int BCD_BITS       = DIGITS * 4;
   localparam int SHIFT_CNT_BITS = $clog2(LEN_MAX_BITS + 1);
   localparam int DIGIT_IDX_BITS = $clog2(DIGITS);

   localparam logic [7:0] ZERO_CHAR = 8'h30;

   typedef struct packed {
      logic [7:0]              letter;
      logic [LEN_MAX_BITS-1:0] len;
      logic                    last;
   } flush_entry_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_CONVERT,
      BK_DIGITS,
      BK_LETTER
   } back_state_type;

endpackage

### sv/letter_run_length_encoder.sv
// Path: the request that ends a run pushes the run into the flush queue and the back end pops it;
// a counted run (three or more) is converted to decimal in BK_CONVERT and leaves as digits then
// letter, one a cycle while the receiver is ready; a run of one or two letters leaves as its letters.
// Throughput: one request a cycle while the flush queue has room and no second entry is pending;
// a request that ends two runs holds req_ready low until the second run's entry is pushed.
// Reset: synchronous, active high; clears the run, the flush queue and the output register.
module letter_run_length_encoder
   import lrle_pkg::*;
#(
   parameter int COUNT_BITS  = COUNT_BITS_DEFAULT,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   input  logic       req_end_of_part,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last_of_burst
);

   logic            push_valid;
   flush_entry_type push_entry;
   logic            pop;
   flush_entry_type pop_entry;
   logic            q_full;
   logic            q_empty;

   lrle_front #(
      .COUNT_BITS (COUNT_BITS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_in_byte     (req_in_byte),
      .req_end_of_part (req_end_of_part),
      .q_full          (q_full),
      .push_valid      (push_valid),
      .push_entry      (push_entry)
   );

   lrle_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push_valid),
      .push_entry (push_entry),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .full       (q_full),
      .empty      (q_empty)
   );

   lrle_back u_back (
      .clock             (clock),
      .reset             (reset),
      .q_empty           (q_empty),
      .q_entry           (pop_entry),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_last_of_burst (rsp_last_of_burst)
   );

endmodule

### sv/lrle_front.sv
module lrle_front
   import lrle_pkg::*;
#(
   parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  logic [7:0]      req_in_byte,
   input  logic            req_end_of_part,
   input  logic            q_full,
   output logic            push_valid,
   output flush_entry_type push_entry
);

   localparam int LEN_BITS = (COUNT_BITS < LEN_MAX_BITS) ? COUNT_BITS : LEN_MAX_BITS;

   logic [7:0]          run_letter_ff, run_letter_in;
   logic [LEN_BITS-1:0] run_len_ff, run_len_in;
   logic                pend_valid_ff, pend_valid_in;
   flush_entry_type     pend_entry_ff, pend_entry_in;

   logic                accept;
   logic                is_letter;
   logic                a_valid, b_valid;
   flush_entry_type     a_entry, b_entry;
   logic [LEN_BITS-1:0] len_inc, len_mid;

   assign accept    = req_valid && req_ready;
   assign req_ready = !pend_valid_ff && !q_full;
   assign is_letter = ((req_in_byte >= 8'h41) && (req_in_byte <= 8'h5a)) ||
                      ((req_in_byte >= 8'h61) && (req_in_byte <= 8'h7a));

   always_comb begin
      a_valid       = 1'b0;
      b_valid       = 1'b0;
      a_entry       = '0;
      b_entry       = '0;
      len_inc       = run_len_ff + 1'b1;
      len_mid       = run_len_ff;
      run_letter_in = run_letter_ff;
      a_entry.letter = run_letter_ff;
      a_entry.len    = LEN_MAX_BITS'(run_len_ff);
      if (is_letter) begin
         if ((run_len_ff != '0) && (req_in_byte == run_letter_ff)) begin
            if (&len_inc) begin
               a_valid     = 1'b1;
               a_entry.len = LEN_MAX_BITS'(len_inc);
               len_mid     = '0;
            end else begin
               len_mid = len_inc;
            end
         end else begin
            a_valid       = (run_len_ff != '0);
            run_letter_in = req_in_byte;
            len_mid       = LEN_BITS'(1);
         end
      end else begin
         a_valid = (run_len_ff != '0);
         len_mid = '0;
      end
      run_len_in = len_mid;
      if (req_end_of_part && (len_mid != '0)) begin
         b_valid        = 1'b1;
         b_entry.letter = run_letter_in;
         b_entry.len    = LEN_MAX_BITS'(len_mid);
         b_entry.last   = 1'b1;
         run_len_in     = '0;
      end
      a_entry.last = !b_valid;

      pend_valid_in = pend_valid_ff;
      pend_entry_in = pend_entry_ff;
      if (pend_valid_ff && !q_full) begin
         pend_valid_in = 1'b0;
      end else if (accept && a_valid && b_valid) begin
         pend_valid_in = 1'b1;
         pend_entry_in = b_entry;
      end

      if (pend_valid_ff) begin
         push_valid = !q_full;
         push_entry = pend_entry_ff;
      end else begin
         push_valid = accept && (a_valid || b_valid);
         push_entry = a_valid ? a_entry : b_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_letter_ff <= '0;
         run_len_ff    <= '0;
         pend_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            run_letter_ff <= run_letter_in;
            run_len_ff    <= run_len_in;
         end
         pend_valid_ff <= pend_valid_in;
      end
      pend_entry_ff <= pend_entry_in;
   end

endmodule

### sv/lrle_queue.sv
`include "letter_run_length_encoder_assert.svh"

module lrle_queue
   import lrle_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  flush_entry_type push_entry,
   input  logic            pop,
   output flush_entry_type pop_entry,
   output logic            full,
   output logic            empty
);

   localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   flush_entry_type     mem_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;

   assign full      = (count_ff == CNT_BITS'(QUEUE_DEPTH));
   assign empty     = (count_ff == '0);
   assign pop_entry = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   `LRLE_ASSERT_IMPLY(a_no_push_full, push, !full, "push into full queue")
   `LRLE_ASSERT_IMPLY(a_no_pop_empty, pop, !empty, "pop from empty queue")

endmodule

### sv/lrle_back.sv
`include "letter_run_length_encoder_assert.svh"

module lrle_back
   import lrle_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            q_empty,
   input  flush_entry_type q_entry,
   output logic            pop,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output logic [7:0]      rsp_out_byte,
   output logic            rsp_last_of_burst
);

   back_state_type            state_ff, state_in;
   logic [7:0]                letter_ff, letter_in;
   logic                      last_ff, last_in;
   logic                      rep_ff, rep_in;
   logic [LEN_MAX_BITS-1:0]   bin_ff, bin_in;
   logic [BCD_BITS-1:0]       bcd_ff, bcd_in;
   logic [SHIFT_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [DIGIT_IDX_BITS-1:0] idx_ff, idx_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [7:0]                rsp_byte_ff, rsp_byte_in;
   logic                      rsp_last_ff, rsp_last_in;

   logic                      load;
   logic                      emit;
   logic [7:0]                emit_byte;
   logic                      emit_last;
   logic [BCD_BITS-1:0]       bcd_adj;
   logic [BCD_BITS-1:0]       bcd_shift;
   logic [DIGIT_IDX_BITS-1:0] lead_idx;
   logic [3:0]                digit;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_byte      = rsp_byte_ff;
   assign rsp_last_of_burst = rsp_last_ff;
   assign load              = !rsp_valid_ff || rsp_ready;

   always_comb begin
      for (int i = 0; i < DIGITS; i++) begin
         bcd_adj[i*4 +: 4] = (bcd_ff[i*4 +: 4] >= 4'd5) ? bcd_ff[i*4 +: 4] + 4'd3
                                                          : bcd_ff[i*4 +: 4];
      end
      bcd_shift = {bcd_adj[BCD_BITS-2:0], bin_ff[LEN_MAX_BITS-1]};
      lead_idx  = '0;
      for (int i = 0; i < DIGITS; i++) begin
         if (bcd_shift[i*4 +: 4] != 4'd0) begin
            lead_idx = DIGIT_IDX_BITS'(i);
         end
      end
      digit = 4'd0;
      for (int i = 0; i < DIGITS; i++) begin
         if (idx_ff == DIGIT_IDX_BITS'(i)) begin
            digit = bcd_ff[i*4 +: 4];
         end
      end
   end

   always_comb begin
      state_in  = state_ff;
      letter_in = letter_ff;
      last_in   = last_ff;
      rep_in    = rep_ff;
      bin_in    = bin_ff;
      bcd_in    = bcd_ff;
      cnt_in    = cnt_ff;
      idx_in    = idx_ff;
      pop       = 1'b0;
      emit      = 1'b0;
      emit_byte = '0;
      emit_last = 1'b0;
      case (state_ff)
         BK_IDLE: begin
            if (!q_empty) begin
               pop       = 1'b1;
               letter_in = q_entry.letter;
               last_in   = q_entry.last;
               if (q_entry.len > LEN_MAX_BITS'(2)) begin
                  bin_in   = q_entry.len;
                  bcd_in   = '0;
                  cnt_in   = SHIFT_CNT_BITS'(LEN_MAX_BITS);
                  state_in = BK_CONVERT;
               end else begin
                  rep_in   = (q_entry.len == LEN_MAX_BITS'(2));
                  state_in = BK_LETTER;
               end
            end
         end
         BK_CONVERT: begin
            bcd_in = bcd_shift;
            bin_in = {bin_ff[LEN_MAX_BITS-2:0], 1'b0};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == SHIFT_CNT_BITS'(1)) begin
               idx_in   = lead_idx;
               state_in = BK_DIGITS;
            end
         end
         BK_DIGITS: begin
            if (load) begin
               emit      = 1'b1;
               emit_byte = ZERO_CHAR + {4'd0, digit};
               if (idx_ff == '0) begin
                  rep_in   = 1'b0;
                  state_in = BK_LETTER;
               end else begin
                  idx_in = idx_ff - 1'b1;
               end
            end
         end
         BK_LETTER: begin
            if (load) begin
               emit      = 1'b1;
               emit_byte = letter_ff;
               emit_last = last_ff && !rep_ff;
               if (rep_ff) begin
                  rep_in = 1'b0;
               end else begin
                  state_in = BK_IDLE;
               end
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase

      rsp_valid_in = rsp_valid_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      if (load) begin
         rsp_valid_in = emit;
         rsp_byte_in  = emit_byte;
         rsp_last_in  = emit_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      letter_ff   <= letter_in;
      last_ff     <= last_in;
      rep_ff      <= rep_in;
      bin_ff      <= bin_in;
      bcd_ff      <= bcd_in;
      cnt_ff      <= cnt_in;
      idx_ff      <= idx_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
   end

   `LRLE_ASSERT_IMPLY(a_pop_len_nonzero, pop, q_entry.len != '0, "empty run dequeued")
   `LRLE_ASSERT_NEVER(a_digit_range, (state_ff == BK_DIGITS) && (digit > 4'd9), "bad BCD digit")

endmodule

### verif/testbench.sv
module testbench;
   import lrle_pkg::*;

   localparam int RUN_CAP     = (COUNT_BITS_DEFAULT >= 16) ? 65535
                                                           : (1 << COUNT_BITS_DEFAULT) - 1;
   localparam int STALL_LIMIT = 2000;
   localparam int DRAIN       = 60;
   localparam int RANDOM_REQS = 420;

   typedef struct {
      logic [7:0] data;
      logic       eop;
      logic       hold;
   } stim_req_type;

   typedef struct {
      logic [7:0] code;
      logic       last;
   } enc_byte_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_in_byte = 8'h00;
   logic       req_end_of_part = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_last_of_burst;

   stim_req_type pending_reqs[$];
   enc_byte_type due_bytes[$];
   enc_byte_type burst[$];
   logic [7:0]   run_chr = 8'h00;
   int           run_len = 0;
   int           mismatches = 0;
   int           n_total = 0;
   int           n_accepted = 0;
   int           stall_cycles = 0;
   int           calm_lo = 0;
   int           calm_hi = 0;
   logic         req_taken = 1'b0;
   logic         calm;

   assign calm = (n_accepted >= calm_lo) && (n_accepted < calm_hi);

   letter_run_length_encoder uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_in_byte       (req_in_byte),
      .req_end_of_part   (req_end_of_part),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_last_of_burst (rsp_last_of_burst)
   );

   always #5 clock = ~clock;

   task automatic note_mismatch(input string what);
      $display("ERROR: %s", what);
      mismatches++;
   endtask

   function automatic logic is_letter(input logic [7:0] b);
      return (b >= "A" && b <= "Z") || (b >= "a" && b <= "z");
   endfunction

   function automatic logic [7:0] rand_letter();
      if ($urandom_range(1) == 1) begin
         return 8'h41 + 8'($urandom_range(25));
      end
      return 8'h61 + 8'($urandom_range(25));
   endfunction

   task automatic flush_run();
      logic [7:0] digits[$];
      int         len;
      len = run_len;
      if (len == 0) begin
         return;
      end
      if (len < 3) begin
         repeat (len) burst.push_back('{run_chr, 1'b0});
      end else begin
         while (len != 0) begin
            digits.push_front(ZERO_CHAR + 8'(len % 10));
            len = len / 10;
         end
         foreach (digits[i]) burst.push_back('{digits[i], 1'b0});
         burst.push_back('{run_chr, 1'b0});
      end
      run_len = 0;
   endtask

   task automatic encode_request(input logic [7:0] b, input logic eop);
      enc_byte_type tail;
      burst.delete();
      if (is_letter(b)) begin
         if (run_len != 0 && b == run_chr) begin
            run_len++;
            if (run_len >= RUN_CAP) begin
               flush_run();
            end
         end else begin
            flush_run();
            run_chr = b;
            run_len = 1;
         end
      end else begin
         flush_run();
      end
      if (eop) begin
         flush_run();
      end
      if (burst.size() != 0) begin
         tail = burst.pop_back();
         tail.last = 1'b1;
         burst.push_back(tail);
      end
      foreach (burst[i]) due_bytes.push_back(burst[i]);
   endtask

   task automatic add_req(input logic [7:0] b, input logic eop, input logic hold);
      pending_reqs.push_back('{b, eop, hold});
   endtask

   task automatic add_run(input logic [7:0] b, input int len, input logic eop,
                          input logic hold);
      for (int i = 0; i < len; i++) begin
         add_req(b, eop && (i == len - 1), hold && (i == 0));
      end
   endtask

   always @(negedge clock) begin
      if (!reset) begin
         rsp_ready <= calm || ($urandom_range(99) >= 33);
         if (!req_valid || req_taken) begin
            if (pending_reqs.size() != 0
                && !(pending_reqs[0].hold && due_bytes.size() != 0)
                && (calm || $urandom_range(99) >= 33)) begin
               req_valid       <= 1'b1;
               req_in_byte     <= pending_reqs[0].data;
               req_end_of_part <= pending_reqs[0].eop;
               void'(pending_reqs.pop_front());
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      enc_byte_type want;
      if (reset) begin
         req_taken    <= 1'b0;
         stall_cycles <= 0;
      end else begin
         req_taken <= req_valid && req_ready;
         if (req_valid && req_ready) begin
            encode_request(req_in_byte, req_end_of_part);
            n_accepted <= n_accepted + 1;
         end
         if (rsp_valid && rsp_ready) begin
            if (due_bytes.size() == 0) begin
               note_mismatch($sformatf("unexpected byte %h last %b",
                                       rsp_out_byte, rsp_last_of_burst));
            end else begin
               want = due_bytes.pop_front();
               if (rsp_out_byte !== want.code) begin
                  note_mismatch($sformatf("out_byte %h, wanted %h", rsp_out_byte, want.code));
               end
               if (rsp_last_of_burst !== want.last) begin
                  note_mismatch($sformatf("last_of_burst %b, wanted %b on byte %h",
                                          rsp_last_of_burst, want.last, want.code));
               end
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            stall_cycles <= 0;
         end else begin
            stall_cycles <= stall_cycles + 1;
         end
      end
   end

   initial begin : watchdog
      while (stall_cycles < STALL_LIMIT) @(posedge clock);
      $display("Mismatches found");
      $finish;
   end

   initial begin : stimulus
      int         n_rand;
      int         len;
      int         pick;
      logic [7:0] chr;
      logic       eop;

      add_req("A", 1'b1, 1'b0);
      add_run("z", 2, 1'b1, 1'b0);
      add_run("Q", 3, 1'b1, 1'b0);
      add_req("a", 1'b0, 1'b0);
      add_req("A", 1'b0, 1'b0);
      add_req("a", 1'b1, 1'b0);
      add_req(8'h00, 1'b1, 1'b0);
      add_req("Z", 1'b0, 1'b0);
      add_req(8'hFF, 1'b0, 1'b0);
      add_req("b", 1'b0, 1'b0);
      add_req(8'h80, 1'b1, 1'b0);
      add_req("M", 1'b0, 1'b0);
      add_req(8'h40, 1'b0, 1'b0);
      add_req("N", 1'b0, 1'b0);
      add_req(8'h5B, 1'b0, 1'b0);
      add_req(8'h60, 1'b0, 1'b0);
      add_req(8'h7B, 1'b0, 1'b0);
      add_run("y", 12, 1'b0, 1'b0);
      add_req(8'h7F, 1'b1, 1'b0);

      calm_lo = pending_reqs.size() + 150;
      calm_hi = calm_lo + 150;
      n_rand  = 0;
      while (n_rand < RANDOM_REQS) begin
         pick = $urandom_range(99);
         if (pick < 75) begin
            chr  = rand_letter();
            pick = $urandom_range(99);
            if (pick < 70) begin
               len = $urandom_range(4, 1);
            end else if (pick < 95) begin
               len = $urandom_range(30, 5);
            end else begin
               len = $urandom_range(120, 95);
            end
            eop = ($urandom_range(99) < 30);
            add_run(chr, len, eop, (n_rand == 0) || ($urandom_range(99) < 3));
            n_rand += len;
         end else begin
            add_req(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b0);
            n_rand++;
         end
      end

      add_req("b", 1'b1, 1'b0);
      add_run("c", 3, 1'b1, 1'b0);
      n_total = pending_reqs.size();

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (!(n_accepted == n_total && due_bytes.size() == 0)) @(negedge clock);
      repeat (DRAIN) @(negedge clock);
      if (due_bytes.size() != 0) begin
         note_mismatch($sformatf("%0d bytes never arrived", due_bytes.size()));
      end
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
